// ===== hdl/cbpf_pkg.sv =====
package cbpf_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int MAX_DIM = 4096;

  localparam int TABLE_AW = $clog2(TABLE_DEPTH);
  localparam int COL_W = $clog2(MAX_DIM);
  localparam int DIM_W = 13;
  localparam int POS_W = 12;
  localparam int IDX_W = 24;
  localparam int CH_W = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);
  localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);

  // Blend quotient x / 1275 is taken as (x * BLEND_MUL) >> BLEND_SHIFT, exact for x < 2^18.
  localparam int BLEND_SHIFT = 28;
  localparam logic [17:0] BLEND_MUL = 18'd210538;
  localparam logic [17:0] BLEND_ROUND = 18'd637;
  localparam logic [CH_W-1:0] WHITE_PART = 8'd102;
  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH = 3'd0,
    REG_BAR_LEFT    = 3'd1,
    REG_BAR_BOTTOM  = 3'd2,
    REG_BAR_WIDTH   = 3'd3,
    REG_BAR_HEIGHT  = 3'd4,
    REG_HORIZONTAL  = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic             draw;
    logic [IDX_W-1:0] word;
    logic [COL_W-1:0] rem;
    logic [31:0]      rgba;
  } stage_t;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [POS_W-1:0] bar_left;
    logic [POS_W-1:0] bar_bottom;
    logic [DIM_W-1:0] bar_width;
    logic [DIM_W-1:0] bar_height;
    logic             horizontal;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] offset;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
  } result_t;

endpackage

// ===== hdl/cbpf_div_cell.sv =====
module cbpf_div_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic [cbpf_pkg::DIM_W-1:0]      divisor,
  input  logic                            din_valid,
  input  cbpf_pkg::stage_t                din,
  output logic                            dout_valid,
  output cbpf_pkg::stage_t                dout
);

  logic [cbpf_pkg::COL_W:0]   trial;
  logic                       fits;
  logic [cbpf_pkg::COL_W:0]   diff;
  cbpf_pkg::stage_t           step;
  logic                       valid;
  cbpf_pkg::stage_t           data;

  always_comb begin
    trial = {din.rem, din.word[cbpf_pkg::IDX_W-1]};
    fits = ({1'b0, trial} >= {1'b0, divisor});
    diff = trial - divisor;
    step = din;
    if (din.draw) begin
      step.word = {din.word[cbpf_pkg::IDX_W-2:0], fits};
      step.rem = fits ? diff[cbpf_pkg::COL_W-1:0] : trial[cbpf_pkg::COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= din_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= step;
    end
  end

  assign dout_valid = valid;
  assign dout = data;

endmodule

// ===== hdl/cbpf_color_stage.sv =====
module cbpf_color_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  cbpf_pkg::cfg_t       cfg,
  input  logic                 din_valid,
  input  cbpf_pkg::stage_t     din,
  output logic                 dout_valid,
  output cbpf_pkg::result_t    dout
);

  logic [31:0] mem [cbpf_pkg::TABLE_DEPTH];

  logic [cbpf_pkg::IDX_W-1:0]    sample;
  logic [cbpf_pkg::TABLE_AW-1:0] rd_addr;
  logic                          load_ok;

  logic                          c1_valid;
  logic [31:0]                   c1_entry;
  logic [cbpf_pkg::IDX_W-1:0]    c1_rb;
  logic [cbpf_pkg::COL_W-1:0]    c1_col;
  logic [cbpf_pkg::IDX_W-1:0]    c1_cross;
  logic [cbpf_pkg::DIM_W-1:0]    c1_size;

  logic [cbpf_pkg::CH_W-1:0]     a1;
  logic [31:0]                   cross255;
  logic [31:0]                   asize;
  logic [36:0]                   rb_prod;

  logic                          c2_valid;
  logic                          c2_blend;
  logic [15:0]                   c2_ca_r;
  logic [15:0]                   c2_ca_g;
  logic [15:0]                   c2_ca_b;
  logic [23:0]                   c2_rgb;
  logic [cbpf_pkg::IDX_W-1:0]    c2_base;
  logic [cbpf_pkg::COL_W:0]      c2_colsum;

  logic [17:0]                   x_r;
  logic [17:0]                   x_g;
  logic [17:0]                   x_b;
  logic [35:0]                   p_r;
  logic [35:0]                   p_g;
  logic [35:0]                   p_b;

  logic                          c3_valid;
  logic                          c3_blend;
  logic [cbpf_pkg::CH_W-1:0]     c3_q_r;
  logic [cbpf_pkg::CH_W-1:0]     c3_q_g;
  logic [cbpf_pkg::CH_W-1:0]     c3_q_b;
  logic [23:0]                   c3_rgb;
  logic [cbpf_pkg::IDX_W-1:0]    c3_offset;

  always_comb begin
    sample = cfg.horizontal ? cbpf_pkg::IDX_W'(din.rem) : din.word;
    rd_addr = sample[cbpf_pkg::TABLE_AW-1:0];
    load_ok = (din.word[cbpf_pkg::IDX_W-1:cbpf_pkg::TABLE_AW] == '0);
  end

  always_ff @(posedge clk) begin
    if (en && din_valid && !din.draw && load_ok) begin
      mem[din.word[cbpf_pkg::TABLE_AW-1:0]] <= din.rgba;
    end
    if (en) begin
      c1_entry <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_rb <= din.word + cbpf_pkg::IDX_W'(cfg.bar_bottom);
      c1_col <= din.rem;
      c1_cross <= cfg.horizontal ? din.word : cbpf_pkg::IDX_W'(din.rem);
      c1_size <= cfg.horizontal ? cfg.bar_height : cfg.bar_width;
    end
  end

  always_comb begin
    a1 = c1_entry[31:24];
    cross255 = {c1_cross, 8'b0} - {8'b0, c1_cross};
    asize = 32'(a1) * 32'(c1_size);
    rb_prod = 37'(c1_rb) * 37'(cfg.image_width);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_blend <= (a1 != cbpf_pkg::ALPHA_OPAQUE) && (cross255 <= asize);
      c2_ca_r <= 16'(c1_entry[7:0]) * 16'(a1);
      c2_ca_g <= 16'(c1_entry[15:8]) * 16'(a1);
      c2_ca_b <= 16'(c1_entry[23:16]) * 16'(a1);
      c2_rgb <= c1_entry[23:0];
      c2_base <= rb_prod[cbpf_pkg::IDX_W-1:0];
      c2_colsum <= {1'b0, c1_col} + {1'b0, cfg.bar_left};
    end
  end

  always_comb begin
    x_r = {2'b0, c2_ca_r} + {1'b0, c2_ca_r, 1'b0} + cbpf_pkg::BLEND_ROUND;
    x_g = {2'b0, c2_ca_g} + {1'b0, c2_ca_g, 1'b0} + cbpf_pkg::BLEND_ROUND;
    x_b = {2'b0, c2_ca_b} + {1'b0, c2_ca_b, 1'b0} + cbpf_pkg::BLEND_ROUND;
    p_r = 36'(x_r) * 36'(cbpf_pkg::BLEND_MUL);
    p_g = 36'(x_g) * 36'(cbpf_pkg::BLEND_MUL);
    p_b = 36'(x_b) * 36'(cbpf_pkg::BLEND_MUL);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3_blend <= c2_blend;
      c3_q_r <= p_r[cbpf_pkg::BLEND_SHIFT +: cbpf_pkg::CH_W];
      c3_q_g <= p_g[cbpf_pkg::BLEND_SHIFT +: cbpf_pkg::CH_W];
      c3_q_b <= p_b[cbpf_pkg::BLEND_SHIFT +: cbpf_pkg::CH_W];
      c3_rgb <= c2_rgb;
      c3_offset <= c2_base + cbpf_pkg::IDX_W'(c2_colsum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
      c2_valid <= 1'b0;
      c3_valid <= 1'b0;
    end else if (en) begin
      c1_valid <= din_valid && din.draw;
      c2_valid <= c1_valid;
      c3_valid <= c2_valid;
    end
  end

  always_comb begin
    dout.offset = c3_offset;
    dout.red = c3_blend ? cbpf_pkg::WHITE_PART + c3_q_r : c3_rgb[7:0];
    dout.green = c3_blend ? cbpf_pkg::WHITE_PART + c3_q_g : c3_rgb[15:8];
    dout.blue = c3_blend ? cbpf_pkg::WHITE_PART + c3_q_b : c3_rgb[23:16];
  end

  assign dout_valid = c3_valid;

endmodule

// ===== hdl/color_bar_pixel_fill.sv =====
// Channel   Handshake                       Payload
// item      item_valid / item_stall         operation, item_index, entry_red..entry_alpha
// result    result_valid / result_stall     pixel_offset, out_red, out_green, out_blue
// config    cfg_valid / cfg_ready           cfg_index, cfg_data
//
// One item is taken per cycle while item_stall is low. A draw item passes through the 24 cells
// of the division chain, one quotient bit per cell, followed by the table read, the multiply
// stages and the output register before its result appears.
// Reset clears the pipeline and restores the register defaults; the color table is not cleared.
// A stalled result is held in the output register and one skid entry; while the
// skid entry is full the whole pipeline holds and item_stall is high.
module color_bar_pixel_fill (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic                               operation,
  input  logic [23:0]                        item_index,
  input  logic [7:0]                         entry_red,
  input  logic [7:0]                         entry_green,
  input  logic [7:0]                         entry_blue,
  input  logic [7:0]                         entry_alpha,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [23:0]                        pixel_offset,
  output logic [7:0]                         out_red,
  output logic [7:0]                         out_green,
  output logic [7:0]                         out_blue,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cbpf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [12:0]                        cfg_data
);

  cbpf_pkg::cfg_t     cfg_reg;
  cbpf_pkg::cfg_t     cfg_eff;
  logic               en;
  logic               skid_full;
  cbpf_pkg::result_t  skid;
  cbpf_pkg::result_t  res;
  logic               tail_valid;
  cbpf_pkg::result_t  tail;

  logic               chain_valid [cbpf_pkg::IDX_W+1];
  cbpf_pkg::stage_t   chain [cbpf_pkg::IDX_W+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.image_width <= 13'd640;
      cfg_reg.bar_left <= '0;
      cfg_reg.bar_bottom <= '0;
      cfg_reg.bar_width <= 13'd1;
      cfg_reg.bar_height <= 13'd1;
      cfg_reg.horizontal <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cbpf_pkg::REG_IMAGE_WIDTH: cfg_reg.image_width <= cfg_data;
        cbpf_pkg::REG_BAR_LEFT:    cfg_reg.bar_left <= cfg_data[cbpf_pkg::POS_W-1:0];
        cbpf_pkg::REG_BAR_BOTTOM:  cfg_reg.bar_bottom <= cfg_data[cbpf_pkg::POS_W-1:0];
        cbpf_pkg::REG_BAR_WIDTH:   cfg_reg.bar_width <= cfg_data;
        cbpf_pkg::REG_BAR_HEIGHT:  cfg_reg.bar_height <= cfg_data;
        cbpf_pkg::REG_HORIZONTAL:  cfg_reg.horizontal <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_eff = cfg_reg;
    if (cfg_reg.image_width > cbpf_pkg::DIM_MAX) begin
      cfg_eff.image_width = cbpf_pkg::DIM_MAX;
    end
    if (cfg_reg.bar_width == '0) begin
      cfg_eff.bar_width = cbpf_pkg::DIM_ONE;
    end else if (cfg_reg.bar_width > cbpf_pkg::DIM_MAX) begin
      cfg_eff.bar_width = cbpf_pkg::DIM_MAX;
    end
    if (cfg_reg.bar_height == '0) begin
      cfg_eff.bar_height = cbpf_pkg::DIM_ONE;
    end else if (cfg_reg.bar_height > cbpf_pkg::DIM_MAX) begin
      cfg_eff.bar_height = cbpf_pkg::DIM_MAX;
    end
  end

  assign en = !skid_full;
  assign item_stall = skid_full;

  always_comb begin
    chain_valid[0] = item_valid;
    chain[0].draw = operation;
    chain[0].word = item_index;
    chain[0].rem = '0;
    chain[0].rgba = {entry_alpha, entry_blue, entry_green, entry_red};
  end

  for (genvar k = 0; k < cbpf_pkg::IDX_W; k++) begin : g_cell
    cbpf_div_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .divisor    (cfg_eff.bar_width),
      .din_valid  (chain_valid[k]),
      .din        (chain[k]),
      .dout_valid (chain_valid[k+1]),
      .dout       (chain[k+1])
    );
  end

  cbpf_color_stage u_color (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .cfg        (cfg_eff),
    .din_valid  (chain_valid[cbpf_pkg::IDX_W]),
    .din        (chain[cbpf_pkg::IDX_W]),
    .dout_valid (tail_valid),
    .dout       (tail)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (!result_valid || !result_stall) begin
        res <= skid;
        result_valid <= 1'b1;
        skid_full <= 1'b0;
      end
    end else if (tail_valid) begin
      if (!result_valid || !result_stall) begin
        res <= tail;
        result_valid <= 1'b1;
      end else begin
        skid <= tail;
        skid_full <= 1'b1;
      end
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  assign pixel_offset = res.offset;
  assign out_red = res.red;
  assign out_green = res.green;
  assign out_blue = res.blue;

endmodule
